// File: rtl/core/modinv_pkg.sv
// Shared types, widths and the microcode store of the modular inverse block.
// Used by the sequencer, the top level and the checker; depends on nothing.
package modinv_pkg;

    localparam int WIDTH = 32;
    localparam int XW    = WIDTH + 2;
    localparam int KW    = $clog2(WIDTH);
    localparam int PCW   = 3;

    typedef enum logic [5:0] {
        OP_WAIT  = 6'b000001,
        OP_NOP   = 6'b000010,
        OP_SETUP = 6'b000100,
        OP_ALIGN = 6'b001000,
        OP_SUB   = 6'b010000,
        OP_SWAP  = 6'b100000
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS  = 3'b001,
        C_R1_ZERO = 3'b010,
        C_SHIFT   = 3'b100
    } t_cond;

    typedef struct packed {
        t_op            op;
        t_cond          cond;
        logic           k_loop;
        logic           finish;
        logic [PCW-1:0] target;
    } t_uword;

    typedef struct packed {
        logic r1_zero;
        logic can_shift;
        logic k_nz;
    } t_status;

    localparam logic [PCW-1:0] PC_IDLE  = 3'd0;
    localparam logic [PCW-1:0] PC_TEST  = 3'd1;
    localparam logic [PCW-1:0] PC_SETUP = 3'd2;
    localparam logic [PCW-1:0] PC_ALIGN = 3'd3;
    localparam logic [PCW-1:0] PC_SUB   = 3'd4;
    localparam logic [PCW-1:0] PC_SWAP  = 3'd5;
    localparam logic [PCW-1:0] PC_DONE  = 3'd6;

    function automatic t_uword ucode(input logic [PCW-1:0] pc);
        t_uword w;
        w = '{op: OP_WAIT, cond: C_ALWAYS, k_loop: 1'b0, finish: 1'b0, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:  w = '{OP_WAIT,  C_ALWAYS,  1'b0, 1'b0, PC_IDLE};
            PC_TEST:  w = '{OP_NOP,   C_R1_ZERO, 1'b0, 1'b0, PC_DONE};
            PC_SETUP: w = '{OP_SETUP, C_ALWAYS,  1'b0, 1'b0, PC_ALIGN};
            PC_ALIGN: w = '{OP_ALIGN, C_SHIFT,   1'b0, 1'b0, PC_ALIGN};
            PC_SUB:   w = '{OP_SUB,   C_ALWAYS,  1'b1, 1'b0, PC_SUB};
            PC_SWAP:  w = '{OP_SWAP,  C_ALWAYS,  1'b0, 1'b0, PC_TEST};
            PC_DONE:  w = '{OP_NOP,   C_ALWAYS,  1'b0, 1'b1, PC_IDLE};
            default:  w = '{OP_WAIT,  C_ALWAYS,  1'b0, 1'b0, PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/modinv_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on modinv_pkg.
module modinv_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  modinv_pkg::t_status      i_status,
    output modinv_pkg::t_uword       o_uword,
    output logic                     o_busy
);

    logic [modinv_pkg::PCW-1:0] r_pc;
    logic [modinv_pkg::PCW-1:0] n_pc;
    modinv_pkg::t_uword         w;
    logic                       take;

    assign w       = modinv_pkg::ucode(r_pc);
    assign o_uword = w;
    assign o_busy  = (r_pc != modinv_pkg::PC_IDLE);

    always_comb begin
        unique case (w.cond)
            modinv_pkg::C_ALWAYS:  take = 1'b1;
            modinv_pkg::C_R1_ZERO: take = i_status.r1_zero;
            modinv_pkg::C_SHIFT:   take = i_status.can_shift;
            default:               take = 1'b1;
        endcase
    end

    always_comb begin
        n_pc = r_pc + 1'b1;
        priority if (w.op == modinv_pkg::OP_WAIT) begin
            n_pc = i_go ? modinv_pkg::PC_TEST : modinv_pkg::PC_IDLE;
        end else if (w.k_loop) begin
            n_pc = i_status.k_nz ? w.target : r_pc + 1'b1;
        end else if (take) begin
            n_pc = w.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= modinv_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: rtl/core/modular_inverse_ext_euclid.sv
// Top level of the modular inverse block: remainder and coefficient datapath.
// Depends on modinv_pkg and modinv_seq.
//
// A request is taken at a clock edge with start high and busy low; i_value and
// i_modulus are sampled there. busy stays high while the request is worked on.
// The block runs Euclid's steps, each a restoring shift-subtract division that
// updates the signed coefficient of the value along with the remainder.
// Each division first shifts the divisor up in the align loop of the sequencer and then
// subtracts and shifts it down in the subtract loop; a zero modulus goes straight from
// the test step to the result.
// The result appears on o_inverse, o_common_divisor and o_has_inverse for exactly
// one cycle with o_valid high; the receiver cannot stall it. busy is low in that
// cycle, so a new request may be taken at the same edge.
// Synchronous reset returns the sequencer to idle and drops o_valid; a request in
// flight is lost.
module modular_inverse_ext_euclid (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [modinv_pkg::WIDTH-1:0] i_value,
    input  logic [modinv_pkg::WIDTH-1:0] i_modulus,
    output logic                         o_valid,
    output logic [modinv_pkg::WIDTH-1:0] o_inverse,
    output logic [modinv_pkg::WIDTH-1:0] o_common_divisor,
    output logic                         o_has_inverse
);

    localparam int W  = modinv_pkg::WIDTH;
    localparam int XW = modinv_pkg::XW;
    localparam int KW = modinv_pkg::KW;

    modinv_pkg::t_uword  uw;
    modinv_pkg::t_status st;
    logic                go;

    logic [W-1:0]         r_r0, n_r0, r_r1, n_r1, r_d, n_d, r_mod, n_mod;
    logic signed [XW-1:0] r_x0, n_x0, r_x1, n_x1, r_xd, n_xd;
    logic [KW-1:0]        r_k, n_k;
    logic                 r_track, n_track;
    logic                 r_valid;
    logic [W-1:0]         r_inv, r_gcd;
    logic                 r_ok;

    logic                 fits;
    logic                 ok;
    logic signed [XW-1:0] x_fix;

    assign go = start && !busy;

    modinv_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_status (st),
        .o_uword  (uw),
        .o_busy   (busy)
    );

    assign fits         = ({r_d, 1'b0} <= {1'b0, r_r0}) && !r_d[W-1];
    assign st.r1_zero   = (r_r1 == '0);
    assign st.can_shift = fits;
    assign st.k_nz      = (r_k != '0);

    always_comb begin
        n_r0    = r_r0;
        n_r1    = r_r1;
        n_d     = r_d;
        n_mod   = r_mod;
        n_x0    = r_x0;
        n_x1    = r_x1;
        n_xd    = r_xd;
        n_k     = r_k;
        n_track = r_track;
        unique case (uw.op)
            modinv_pkg::OP_WAIT: begin
                if (go) begin
                    n_r0    = i_value;
                    n_r1    = i_modulus;
                    n_mod   = i_modulus;
                    n_x0    = XW'(1);
                    n_x1    = '0;
                    n_track = (i_modulus > W'(1));
                end
            end
            modinv_pkg::OP_NOP: begin
            end
            modinv_pkg::OP_SETUP: begin
                n_d  = r_r1;
                n_xd = r_x1;
                n_k  = '0;
            end
            modinv_pkg::OP_ALIGN: begin
                if (fits) begin
                    n_d  = {r_d[W-2:0], 1'b0};
                    n_xd = r_xd <<< 1;
                    n_k  = r_k + 1'b1;
                end
            end
            modinv_pkg::OP_SUB: begin
                if (r_d <= r_r0) begin
                    n_r0 = r_r0 - r_d;
                    n_x0 = r_x0 - r_xd;
                end
                n_d  = r_d >> 1;
                n_xd = r_xd >>> 1;
                if (r_k != '0) begin
                    n_k = r_k - 1'b1;
                end
            end
            modinv_pkg::OP_SWAP: begin
                n_r0 = r_r1;
                n_r1 = r_r0;
                n_x0 = r_x1;
                n_x1 = r_x0;
            end
            default: begin
            end
        endcase
    end

    assign ok    = r_track && (r_r0 == W'(1));
    assign x_fix = r_x0[XW-1] ? (r_x0 + $signed({2'b00, r_mod})) : r_x0;

    always_ff @(posedge i_clk) begin
        r_r0    <= n_r0;
        r_r1    <= n_r1;
        r_d     <= n_d;
        r_mod   <= n_mod;
        r_x0    <= n_x0;
        r_x1    <= n_x1;
        r_xd    <= n_xd;
        r_k     <= n_k;
        r_track <= n_track;
        if (uw.finish) begin
            r_gcd <= r_r0;
            r_ok  <= ok;
            r_inv <= ok ? x_fix[W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= uw.finish;
        end
    end

    assign o_valid          = r_valid;
    assign o_inverse        = r_inv;
    assign o_common_divisor = r_gcd;
    assign o_has_inverse    = r_ok;

endmodule

// File: rtl/core/modinv_checker.sv
// Port-level checker for the modular inverse block, bound to the top level.
// Depends on modinv_pkg and modular_inverse_ext_euclid.
module modinv_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic [modinv_pkg::WIDTH-1:0] o_inverse,
    input logic [modinv_pkg::WIDTH-1:0] o_common_divisor,
    input logic                         o_has_inverse
);

    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy stayed low");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe without a request in flight");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_inv_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_inverse) |-> (o_common_divisor == modinv_pkg::WIDTH'(1)))
        else $error("inverse flagged with gcd other than one");

    a_no_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_inverse) |-> (o_inverse == '0))
        else $error("nonzero inverse without inverse flag");

endmodule

bind modular_inverse_ext_euclid modinv_checker u_modinv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_inverse        (o_inverse),
    .o_common_divisor (o_common_divisor),
    .o_has_inverse    (o_has_inverse)
);

// File: verif/modinv_inverse_check.sv
`timescale 1ns / 100ps
// Result checker for modular_inverse_ext_euclid: predicts gcd, inverse and flag per request.
// Watches the request and result ports; depends on modinv_pkg for WIDTH.
module modinv_inverse_check
    import modinv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic [WIDTH-1:0] i_value,
    input  logic [WIDTH-1:0] i_modulus,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_inverse,
    input  logic [WIDTH-1:0] i_common_divisor,
    input  logic             i_has_inverse,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        logic [WIDTH-1:0] common_divisor;
        logic             has_inverse;
    } t_inverse_result;

    t_inverse_result expected_inverses[$];
    t_inverse_result oldest;
    int              fails;

    function automatic t_inverse_result compute_inverse(input logic [WIDTH-1:0] value,
                                                        input logic [WIDTH-1:0] modulus);
        logic [2*WIDTH-1:0] m;
        logic [2*WIDTH-1:0] r_prev;
        logic [2*WIDTH-1:0] r_curr;
        logic [2*WIDTH-1:0] r_next;
        logic [2*WIDTH-1:0] quot;
        logic [2*WIDTH-1:0] prod;
        logic [2*WIDTH-1:0] x_prev;
        logic [2*WIDTH-1:0] x_curr;
        logic [2*WIDTH-1:0] x_next;
        logic               track;
        t_inverse_result    res;
        m      = (2*WIDTH)'(modulus);
        r_prev = (2*WIDTH)'(value);
        r_curr = (2*WIDTH)'(modulus);
        x_prev = (2*WIDTH)'(1);
        x_curr = '0;
        track  = (modulus > WIDTH'(1));
        while (r_curr != '0) begin
            quot   = r_prev / r_curr;
            r_next = r_prev % r_curr;
            r_prev = r_curr;
            r_curr = r_next;
            if (track) begin
                // keep the coefficient as its residue mod m
                prod   = (quot * x_curr) % m;
                x_next = (x_prev >= prod) ? (x_prev - prod) : (x_prev + (m - prod));
                x_prev = x_curr;
                x_curr = x_next;
            end
        end
        res.has_inverse    = track && (r_prev == (2*WIDTH)'(1));
        res.inverse        = res.has_inverse ? x_prev[WIDTH-1:0] : '0;
        res.common_divisor = r_prev[WIDTH-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid) begin
                if (expected_inverses.size() == 0) begin
                    $error("unexpected result: inverse %0h, common_divisor %0h, has_inverse %0b",
                           i_inverse, i_common_divisor, i_has_inverse);
                    fails++;
                end else begin
                    oldest = expected_inverses.pop_front();
                    if (i_inverse !== oldest.inverse) begin
                        $error("inverse: expected %0h, actual %0h", oldest.inverse, i_inverse);
                        fails++;
                    end
                    if (i_common_divisor !== oldest.common_divisor) begin
                        $error("common_divisor: expected %0h, actual %0h",
                               oldest.common_divisor, i_common_divisor);
                        fails++;
                    end
                    if (i_has_inverse !== oldest.has_inverse) begin
                        $error("has_inverse: expected %0b, actual %0b",
                               oldest.has_inverse, i_has_inverse);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_inverses.push_back(compute_inverse(i_value, i_modulus));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_inverses.size();
    end

endmodule

// File: verif/modular_inverse_ext_euclid_tb.sv
`timescale 1ns / 100ps
// Top of the modular inverse testbench: clock, reset, directed and random requests, verdict.
// Depends on modinv_pkg, the block modular_inverse_ext_euclid and modinv_inverse_check.
module modular_inverse_ext_euclid_tb;
    import modinv_pkg::*;

    localparam int REQUESTS     = 1650;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 300;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             start     = 1'b0;
    logic [WIDTH-1:0] i_value   = '0;
    logic [WIDTH-1:0] i_modulus = '0;
    logic             busy;
    logic             o_valid;
    logic [WIDTH-1:0] o_inverse;
    logic [WIDTH-1:0] o_common_divisor;
    logic             o_has_inverse;
    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    int               issued      = 0;
    int unsigned      burst;
    int unsigned      pick;
    int unsigned      factor;
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] modulus;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    modular_inverse_ext_euclid dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_value          (i_value),
        .i_modulus        (i_modulus),
        .o_valid          (o_valid),
        .o_inverse        (o_inverse),
        .o_common_divisor (o_common_divisor),
        .o_has_inverse    (o_has_inverse)
    );

    modinv_inverse_check inverse_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_value          (i_value),
        .i_modulus        (i_modulus),
        .i_valid          (o_valid),
        .i_inverse        (o_inverse),
        .i_common_divisor (o_common_divisor),
        .i_has_inverse    (o_has_inverse),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic issue_request(input logic [WIDTH-1:0] req_value,
                                 input logic [WIDTH-1:0] req_modulus);
        start     <= 1'b1;
        i_value   <= req_value;
        i_modulus <= req_modulus;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        issued++;
    endtask

    task automatic hold_off(input int unsigned cycles);
        start     <= 1'b0;
        i_value   <= WIDTH'($urandom);
        i_modulus <= WIDTH'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [WIDTH-1:0] random_operand();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            return WIDTH'($urandom);
        end else if (sel < 75) begin
            return WIDTH'($urandom_range(0, 255));
        end else if (sel < 85) begin
            return {WIDTH{1'b1}} - WIDTH'($urandom_range(0, 255));
        end else if (sel < 92) begin
            return {{(WIDTH-1){1'b0}}, 1'b1} << $urandom_range(0, WIDTH - 1);
        end else begin
            return WIDTH'($urandom_range(0, 3));
        end
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        hold_off(2);

        issue_request(32'h0000_0000, 32'h0000_0000);
        issue_request(32'h0000_0005, 32'h0000_0000);
        issue_request(32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(32'h0000_0007, 32'h0000_0001);
        issue_request(32'h0000_0000, 32'h0000_0001);
        issue_request(32'h0000_0001, 32'h0000_0001);
        issue_request(32'h0000_0000, 32'h0000_0007);
        issue_request(32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(32'h0000_0001, 32'h0000_0002);
        issue_request(32'h0000_0003, 32'h0000_0007);
        issue_request(32'h0000_0007, 32'h0000_0003);
        issue_request(32'h0000_0006, 32'h0000_0009);
        issue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        issue_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        issue_request(32'h0000_0001, 32'hFFFF_FFFF);
        issue_request(32'h0000_0002, 32'hFFFF_FFFF);
        issue_request(32'h8000_0000, 32'hFFFF_FFFF);
        issue_request(32'hFFFF_FFFF, 32'h8000_0000);
        issue_request(32'h0000_0002, 32'h8000_0000);
        issue_request(32'h1234_5679, 32'h8000_0000);
        issue_request(32'd2971215073, 32'd1836311903);
        issue_request(32'd1836311903, 32'd2971215073);
        issue_request(32'hFFFF_FFFF, 32'd4294967291);
        wait_drained();

        while (issued < REQUESTS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                if (issued < REQUESTS) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10) begin
                        factor  = $urandom_range(2, 5000);
                        value   = WIDTH'(factor * $urandom_range(1, 32'hFFFF_FFFF / factor));
                        modulus = WIDTH'(factor * $urandom_range(1, 32'hFFFF_FFFF / factor));
                    end else if (pick < 15) begin
                        value   = random_operand();
                        modulus = WIDTH'($urandom_range(0, 1));
                    end else begin
                        value   = random_operand();
                        modulus = random_operand();
                    end
                    issue_request(value, modulus);
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end else if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    hold_off($urandom_range(1, 250));
                end else begin
                    hold_off($urandom_range(1, 6));
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/modinv_pkg.sv
rtl/core/modinv_seq.sv
rtl/core/modular_inverse_ext_euclid.sv
rtl/core/modinv_checker.sv
verif/modinv_inverse_check.sv
verif/modular_inverse_ext_euclid_tb.sv
